>>> rtl/scc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_ADD_WR,
    S_ADD_LINK,
    S_P1_SCAN,
    S_P2_RD,
    S_P2_CHK,
    S_WALK_HEAD,
    S_WALK_STEP,
    S_WALK_EDGE,
    S_WALK_POP,
    S_EMIT_RD,
    S_EMIT_CHK
  } state_t;

endpackage

`default_nettype wire

>>> rtl/scc_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/strongly_connected_components.sv
`timescale 1ns / 1ps
`default_nettype none

// Strongly connected components of a directed graph, two-pass depth-first search.
// Input words (in_*): tuser = 0 adds the edge in tdata, tuser = 1 runs the
// decomposition. An edge add passes through S_ADD_WR and S_ADD_LINK; a rejected
// edge only raises the drop flag carried on every result of the next run.
// A run walks the forward lists, then the reverse lists, visiting each vertex
// and each edge in each pass. It then scans the component memory once per
// component, vertex by vertex, and emits one word per vertex on out_*, grouped by
// component in topological order, tlast on the final word.
// After a run the list heads and tails are swept back to empty, one vertex a
// cycle over all MAX_VERTICES entries; the same sweep follows reset. No word is
// accepted during the sweep; cfg_* writes are always taken.
// A result waits in an output register while out_tready is low and the scan
// holds; a new input word is taken once the run has finished its sweep.
module strongly_connected_components #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wen,
  input  wire logic [6:0]  cfg_wdata,   // vertex_count
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // from_vertex[5:0], to_vertex[11:6], zeros
  input  wire logic        in_tuser,    // op
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [23:0] out_tdata,   // vertex[5:0], component[11:6], component_count[18:12]
  output logic             out_tlast,
  output logic             out_tuser    // edges_dropped
);

  import scc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = VW + 1;
  localparam int EI = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int SW = VW + CW;
  localparam logic [CW-1:0] EMPTY = CW'(MAX_EDGES);

  state_t state_r, state_nxt;

  logic [6:0]              cfg_r;
  logic [CW-1:0]           edge_total_r, edge_total_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [VW-1:0]           clr_addr_r, clr_addr_nxt;
  logic [VW-1:0]           from_r, from_nxt, to_r, to_nxt;
  logic                    pass2_r, pass2_nxt;
  logic [NW-1:0]           depth_r, depth_nxt;
  logic [VW-1:0]           top_v_r, top_v_nxt;
  logic [CW-1:0]           top_cur_r, top_cur_nxt;
  logic [NW-1:0]           scan_r, scan_nxt;
  logic [NW-1:0]           fin_r, fin_nxt;
  logic [NW-1:0]           comps_r, comps_nxt;
  logic [NW-1:0]           cidx_r, cidx_nxt;
  logic [NW-1:0]           emit_cnt_r, emit_cnt_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [23:0]             out_data_r, out_data_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    out_user_r, out_user_nxt;

  // Memory ports.
  logic          edge_we;
  logic [2*VW-1:0] edge_rd;
  logic          fnext_we, rnext_we;
  logic [EI-1:0] fnext_wa, rnext_wa;
  logic [CW-1:0] fnext_wd, rnext_wd, fnext_rd, rnext_rd;
  logic          head_we_f, head_we_r, tail_we_f, tail_we_r;
  logic [VW-1:0] fh_wa, rh_wa, ft_wa, rt_wa;
  logic [CW-1:0] fh_wd, rh_wd, ft_wd, rt_wd;
  logic [CW-1:0] fhead_rd, rhead_rd, ftail_rd, rtail_rd;
  logic [VW-1:0] tail_ra_f, tail_ra_r;
  logic          fin_we, comp_we, stack_we;
  logic [VW-1:0] fin_wa, comp_wa, stack_wa;
  logic [VW-1:0] fin_wd, comp_wd, fin_rd, comp_rd;
  logic [SW-1:0] stack_wd, stack_rd;

  // Combinational helpers.
  logic [NW-1:0] n_c;
  logic [VW-1:0] in_from, in_to;
  logic          add_ok, in_acc, out_free, cur_valid, push_ok, walk_last;
  logic [CW-1:0] next_c;
  logic [VW-1:0] w_c;
  logic [EI-1:0] id_c;

  always_comb begin
    if (cfg_r == 7'd0) begin
      n_c = NW'(1);
    end else if (32'(cfg_r) > MAX_VERTICES) begin
      n_c = NW'(MAX_VERTICES);
    end else begin
      n_c = NW'(cfg_r);
    end
  end

  assign in_from   = VW'(in_tdata[5:0]);
  assign in_to     = VW'(in_tdata[11:6]);
  assign add_ok    = (32'(in_tdata[5:0]) < 32'(n_c)) && (32'(in_tdata[11:6]) < 32'(n_c))
                     && (32'(edge_total_r) < MAX_EDGES);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cur_valid = (top_cur_r < EMPTY);
  assign next_c    = pass2_r ? rnext_rd : fnext_rd;
  // The edge memory holds the source in the upper half and the destination below.
  assign w_c       = pass2_r ? edge_rd[2*VW-1:VW] : edge_rd[VW-1:0];
  assign push_ok   = ({1'b0, w_c} < n_c) && !visited_r[w_c] && (32'(depth_r) < MAX_VERTICES);
  assign walk_last = (depth_r == NW'(1));
  assign id_c      = EI'(edge_total_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (32'(clr_addr_r) == MAX_VERTICES - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) state_nxt = S_P1_SCAN;
          else if (add_ok) state_nxt = S_ADD_WR;
        end
      end
      S_ADD_WR:   state_nxt = S_ADD_LINK;
      S_ADD_LINK: state_nxt = S_IDLE;
      S_P1_SCAN: begin
        if (scan_r == n_c) state_nxt = S_P2_RD;
        else if (!visited_r[VW'(scan_r)]) state_nxt = S_WALK_HEAD;
      end
      S_P2_RD: begin
        if (scan_r == '0) state_nxt = S_EMIT_RD;
        else state_nxt = S_P2_CHK;
      end
      S_P2_CHK: begin
        if ({1'b0, fin_rd} < n_c && !visited_r[fin_rd]) state_nxt = S_WALK_HEAD;
        else state_nxt = S_P2_RD;
      end
      S_WALK_HEAD: state_nxt = S_WALK_STEP;
      S_WALK_STEP: begin
        if (cur_valid) state_nxt = S_WALK_EDGE;
        else if (!walk_last) state_nxt = S_WALK_POP;
        else if (pass2_r) state_nxt = S_P2_RD;
        else state_nxt = S_P1_SCAN;
      end
      S_WALK_EDGE: begin
        if (push_ok) state_nxt = S_WALK_HEAD;
        else state_nxt = S_WALK_STEP;
      end
      S_WALK_POP: state_nxt = S_WALK_STEP;
      S_EMIT_RD: begin
        if (cidx_r == comps_r) state_nxt = S_CLR;
        else state_nxt = S_EMIT_CHK;
      end
      S_EMIT_CHK: begin
        if ({1'b0, comp_rd} != cidx_r || out_free) state_nxt = S_EMIT_RD;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    edge_total_nxt = edge_total_r;
    ovf_nxt        = ovf_r;
    visited_nxt    = visited_r;
    clr_addr_nxt   = clr_addr_r;
    from_nxt       = from_r;
    to_nxt         = to_r;
    pass2_nxt      = pass2_r;
    depth_nxt      = depth_r;
    top_v_nxt      = top_v_r;
    top_cur_nxt    = top_cur_r;
    scan_nxt       = scan_r;
    fin_nxt        = fin_r;
    comps_nxt      = comps_r;
    cidx_nxt       = cidx_r;
    emit_cnt_nxt   = emit_cnt_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_user_nxt   = out_user_r;

    edge_we   = 1'b0;
    fnext_we  = 1'b0;
    rnext_we  = 1'b0;
    fnext_wa  = id_c;
    rnext_wa  = id_c;
    fnext_wd  = EMPTY;
    rnext_wd  = EMPTY;
    head_we_f = 1'b0;
    head_we_r = 1'b0;
    tail_we_f = 1'b0;
    tail_we_r = 1'b0;
    fh_wa     = from_r;
    rh_wa     = to_r;
    ft_wa     = from_r;
    rt_wa     = to_r;
    fh_wd     = CW'(edge_total_r);
    rh_wd     = CW'(edge_total_r);
    ft_wd     = CW'(edge_total_r);
    rt_wd     = CW'(edge_total_r);
    fin_we    = 1'b0;
    fin_wa    = VW'(fin_r);
    fin_wd    = top_v_r;
    comp_we   = 1'b0;
    comp_wa   = top_v_r;
    comp_wd   = VW'(comps_r);
    stack_we  = 1'b0;
    stack_wa  = VW'(depth_r - NW'(1));
    stack_wd  = {top_v_r, next_c};

    case (state_r)
      S_CLR: begin
        head_we_f = 1'b1;
        head_we_r = 1'b1;
        tail_we_f = 1'b1;
        tail_we_r = 1'b1;
        fh_wa = clr_addr_r;
        rh_wa = clr_addr_r;
        ft_wa = clr_addr_r;
        rt_wa = clr_addr_r;
        fh_wd = EMPTY;
        rh_wd = EMPTY;
        ft_wd = EMPTY;
        rt_wd = EMPTY;
        clr_addr_nxt = clr_addr_r + VW'(1);
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            visited_nxt = '0;
            scan_nxt    = '0;
            fin_nxt     = '0;
            pass2_nxt   = 1'b0;
          end else if (add_ok) begin
            from_nxt = in_from;
            to_nxt   = in_to;
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      S_ADD_WR: begin
        // Tails read in the accept cycle; link the new edge behind them.
        edge_we   = 1'b1;
        tail_we_f = 1'b1;
        tail_we_r = 1'b1;
        head_we_f = (ftail_rd == EMPTY);
        head_we_r = (rtail_rd == EMPTY);
        fnext_we  = (ftail_rd != EMPTY);
        rnext_we  = (rtail_rd != EMPTY);
        fnext_wa  = EI'(ftail_rd);
        rnext_wa  = EI'(rtail_rd);
        fnext_wd  = CW'(edge_total_r);
        rnext_wd  = CW'(edge_total_r);
        edge_total_nxt = edge_total_r + CW'(1);
      end
      S_ADD_LINK: begin
        fnext_we = 1'b1;
        rnext_we = 1'b1;
        fnext_wa = EI'(edge_total_r - CW'(1));
        rnext_wa = EI'(edge_total_r - CW'(1));
      end
      S_P1_SCAN: begin
        if (scan_r == n_c) begin
          visited_nxt = '0;
          scan_nxt    = fin_r;
          comps_nxt   = '0;
          pass2_nxt   = 1'b1;
        end else if (!visited_r[VW'(scan_r)]) begin
          top_v_nxt = VW'(scan_r);
          visited_nxt[VW'(scan_r)] = 1'b1;
          depth_nxt = NW'(1);
        end else begin
          scan_nxt = scan_r + NW'(1);
        end
      end
      S_P2_RD: begin
        if (scan_r == '0) begin
          cidx_nxt     = '0;
          emit_cnt_nxt = '0;
        end
      end
      S_P2_CHK: begin
        if ({1'b0, fin_rd} < n_c && !visited_r[fin_rd]) begin
          top_v_nxt = fin_rd;
          visited_nxt[fin_rd] = 1'b1;
          depth_nxt = NW'(1);
          comp_we   = 1'b1;
          comp_wa   = fin_rd;
        end else begin
          scan_nxt = scan_r - NW'(1);
        end
      end
      S_WALK_HEAD: begin
        top_cur_nxt = pass2_r ? rhead_rd : fhead_rd;
      end
      S_WALK_STEP: begin
        if (!cur_valid) begin
          if (!pass2_r && 32'(fin_r) < MAX_VERTICES) begin
            fin_we  = 1'b1;
            fin_nxt = fin_r + NW'(1);
          end
          depth_nxt = depth_r - NW'(1);
          if (walk_last) begin
            if (pass2_r) begin
              comps_nxt = comps_r + NW'(1);
              scan_nxt  = scan_r - NW'(1);
            end else begin
              scan_nxt = scan_r + NW'(1);
            end
          end
        end
      end
      S_WALK_EDGE: begin
        top_cur_nxt = next_c;
        if (push_ok) begin
          stack_we  = 1'b1;
          top_v_nxt = w_c;
          visited_nxt[w_c] = 1'b1;
          depth_nxt = depth_r + NW'(1);
          comp_we   = pass2_r;
          comp_wa   = w_c;
        end
      end
      S_WALK_POP: begin
        {top_v_nxt, top_cur_nxt} = stack_rd;
      end
      S_EMIT_RD: begin
        if (cidx_r == comps_r) begin
          clr_addr_nxt   = '0;
          edge_total_nxt = '0;
          ovf_nxt        = 1'b0;
          visited_nxt    = '0;
        end
      end
      S_EMIT_CHK: begin
        if ({1'b0, comp_rd} != cidx_r || out_free) begin
          if ({1'b0, comp_rd} == cidx_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {5'd0, 7'(comps_r), 6'(cidx_r), 6'(scan_r)};
            out_last_nxt  = (emit_cnt_r + NW'(1) == n_c);
            out_user_nxt  = ovf_r;
            emit_cnt_nxt  = emit_cnt_r + NW'(1);
          end
          if (scan_r == n_c - NW'(1)) begin
            scan_nxt = '0;
            cidx_nxt = cidx_r + NW'(1);
          end else begin
            scan_nxt = scan_r + NW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      cfg_r        <= 7'd64;
      edge_total_r <= '0;
      ovf_r        <= 1'b0;
      visited_r    <= '0;
      clr_addr_r   <= '0;
      depth_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_wen) cfg_r <= cfg_wdata;
      edge_total_r <= edge_total_nxt;
      ovf_r        <= ovf_nxt;
      visited_r    <= visited_nxt;
      clr_addr_r   <= clr_addr_nxt;
      depth_r      <= depth_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    from_r     <= from_nxt;
    to_r       <= to_nxt;
    pass2_r    <= pass2_nxt;
    top_v_r    <= top_v_nxt;
    top_cur_r  <= top_cur_nxt;
    scan_r     <= scan_nxt;
    fin_r      <= fin_nxt;
    comps_r    <= comps_nxt;
    cidx_r     <= cidx_nxt;
    emit_cnt_r <= emit_cnt_nxt;
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  // Tails are read in the accept cycle so that the link is known in S_ADD_WR.
  assign tail_ra_f = (state_r == S_IDLE) ? in_from : from_r;
  assign tail_ra_r = (state_r == S_IDLE) ? in_to : to_r;

  scc_ram #(.WIDTH(2 * VW), .DEPTH(MAX_EDGES)) u_edge (
    .clk, .we(edge_we), .waddr(id_c), .wdata({from_r, to_r}),
    .raddr(top_cur_r[EI-1:0]), .rdata(edge_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES)) u_fnext (
    .clk, .we(fnext_we), .waddr(fnext_wa), .wdata(fnext_wd),
    .raddr(top_cur_r[EI-1:0]), .rdata(fnext_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_EDGES)) u_rnext (
    .clk, .we(rnext_we), .waddr(rnext_wa), .wdata(rnext_wd),
    .raddr(top_cur_r[EI-1:0]), .rdata(rnext_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_fhead (
    .clk, .we(head_we_f), .waddr(fh_wa), .wdata(fh_wd),
    .raddr(top_v_nxt), .rdata(fhead_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_rhead (
    .clk, .we(head_we_r), .waddr(rh_wa), .wdata(rh_wd),
    .raddr(top_v_nxt), .rdata(rhead_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_ftail (
    .clk, .we(tail_we_f), .waddr(ft_wa), .wdata(ft_wd),
    .raddr(tail_ra_f), .rdata(ftail_rd)
  );

  scc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_rtail (
    .clk, .we(tail_we_r), .waddr(rt_wa), .wdata(rt_wd),
    .raddr(tail_ra_r), .rdata(rtail_rd)
  );

  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_fin (
    .clk, .we(fin_we), .waddr(fin_wa), .wdata(fin_wd),
    .raddr(VW'(scan_r - NW'(1))), .rdata(fin_rd)
  );

  scc_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_comp (
    .clk, .we(comp_we), .waddr(comp_wa), .wdata(comp_wd),
    .raddr(VW'(scan_r)), .rdata(comp_rd)
  );

  scc_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stack (
    .clk, .we(stack_we), .waddr(stack_wa), .wdata(stack_wd),
    .raddr(VW'(depth_r - NW'(2))), .rdata(stack_rd)
  );

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(depth_r) <= MAX_VERTICES)
    else $error("walk stack depth beyond capacity");

  a_edge_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(edge_total_r) <= MAX_EDGES)
    else $error("edge count beyond capacity");

  a_bad_edge_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tuser && !add_ok) |=> ovf_r)
    else $error("rejected edge did not raise the drop flag");

  a_no_load_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("pending result overwritten");

  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_RD && cidx_r == comps_r) |-> (emit_cnt_r == n_c))
    else $error("run emitted a wrong number of results");
`endif

endmodule

`default_nettype wire

>>> tb/tb_strongly_connected_components.sv
`timescale 1ns / 1ps

module tb_strongly_connected_components;
  import scc_pkg::*;

  localparam int NV = 64;
  localparam int NE = 256;
  localparam int EMPTY = NE;
  localparam int IDLE_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 200;
  localparam int HOLD_CYCLES = 3000;

  typedef enum bit {OP_ADD = 1'b0, OP_RUN = 1'b1} scc_op_t;

  typedef struct packed {
    bit [5:0] vertex;
    bit [5:0] comp;
    bit [6:0] comp_total;
    bit       last;
    bit       dropped;
  } scc_word_t;

  // Holds a copy of the edge store and the expected result words of each run.
  class scc_scoreboard;
    bit [6:0]  vcount_reg;
    int        edge_src[NE], edge_dst[NE], fwd_next[NE], rev_next[NE];
    int        fwd_head[NV], fwd_tail[NV], rev_head[NV], rev_tail[NV];
    int        edge_total;
    bit        drop_flag;
    bit        seen[NV];
    int        finish_seq[NV];
    int        finish_len;
    int        comp_of[NV];
    int        stack_v[NV], stack_e[NV];
    scc_word_t expected_words[$];

    function new();
      vcount_reg = 7'd64;
      clear_store();
    endfunction

    function void clear_store();
      for (int i = 0; i < NV; i++) begin
        fwd_head[i] = EMPTY; fwd_tail[i] = EMPTY;
        rev_head[i] = EMPTY; rev_tail[i] = EMPTY;
        seen[i] = 0;
      end
      edge_total = 0;
      drop_flag = 0;
    endfunction

    function int active_vertices();
      if (vcount_reg == 0) return 1;
      if (vcount_reg > NV) return NV;
      return vcount_reg;
    endfunction

    function void set_vertex_count(bit [6:0] value);
      vcount_reg = value;
    endfunction

    function void walk(int start, bit rev, int n, int comp);
      int depth, top, e, w;
      seen[start] = 1;
      if (rev) comp_of[start] = comp;
      stack_v[0] = start;
      stack_e[0] = rev ? rev_head[start] : fwd_head[start];
      depth = 1;
      while (depth > 0) begin
        top = depth - 1;
        e = stack_e[top];
        if (e < NE) begin
          stack_e[top] = rev ? rev_next[e] : fwd_next[e];
          w = rev ? edge_src[e] : edge_dst[e];
          if (w < n && !seen[w] && depth < NV) begin
            seen[w] = 1;
            if (rev) comp_of[w] = comp;
            stack_v[depth] = w;
            stack_e[depth] = rev ? rev_head[w] : fwd_head[w];
            depth++;
          end
        end else begin
          if (!rev && finish_len < NV) begin
            finish_seq[finish_len] = stack_v[top];
            finish_len++;
          end
          depth--;
        end
      end
    endfunction

    function void insert_edge(int from_v, int to_v);
      int n, id;
      n = active_vertices();
      id = edge_total;
      if (from_v >= n || to_v >= n || id >= NE) begin
        drop_flag = 1;
        return;
      end
      edge_src[id] = from_v;
      edge_dst[id] = to_v;
      fwd_next[id] = EMPTY;
      rev_next[id] = EMPTY;
      if (fwd_tail[from_v] < NE) fwd_next[fwd_tail[from_v]] = id;
      else fwd_head[from_v] = id;
      fwd_tail[from_v] = id;
      if (rev_tail[to_v] < NE) rev_next[rev_tail[to_v]] = id;
      else rev_head[to_v] = id;
      rev_tail[to_v] = id;
      edge_total = id + 1;
    endfunction

    function void decompose();
      int n, comps, emitted, s;
      scc_word_t wd;
      n = active_vertices();
      comps = 0;
      emitted = 0;
      finish_len = 0;
      for (int i = 0; i < NV; i++) seen[i] = 0;
      for (int v = 0; v < n; v++)
        if (!seen[v]) walk(v, 1'b0, n, 0);
      for (int i = 0; i < NV; i++) seen[i] = 0;
      for (int i = finish_len; i > 0; i--) begin
        s = finish_seq[i - 1];
        if (s < n && !seen[s]) begin
          walk(s, 1'b1, n, comps);
          comps++;
        end
      end
      for (int c = 0; c < comps; c++)
        for (int v = 0; v < n; v++)
          if (comp_of[v] == c) begin
            wd.vertex = v[5:0];
            wd.comp = c[5:0];
            wd.comp_total = comps[6:0];
            wd.last = (emitted + 1 == n);
            wd.dropped = drop_flag;
            expected_words.push_back(wd);
            emitted++;
          end
      clear_store();
    endfunction

    function void note_input(scc_op_t op, int from_v, int to_v);
      if (op == OP_ADD) insert_edge(from_v, to_v);
      else decompose();
    endfunction

    // Returns an empty string on a match, else a description of the fault.
    function string check_word(scc_word_t got);
      scc_word_t exp_w;
      if (expected_words.size() == 0)
        return $sformatf("unexpected word vertex=%0d comp=%0d", got.vertex, got.comp);
      exp_w = expected_words.pop_front();
      if (got != exp_w)
        return $sformatf("got v=%0d c=%0d n=%0d last=%0d drop=%0d, expected v=%0d c=%0d n=%0d last=%0d drop=%0d",
                         got.vertex, got.comp, got.comp_total, got.last, got.dropped,
                         exp_w.vertex, exp_w.comp, exp_w.comp_total, exp_w.last,
                         exp_w.dropped);
      return "";
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wen;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic        out_tuser;

  strongly_connected_components dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

  scc_scoreboard sb = new();
  int  fault_count = 0;
  int  idle_cycles = 0;
  int  words_checked = 0;
  int  edges_sent = 0;
  int  runs_sent = 0;
  int  random_items = 0;
  bit  steady = 0;
  bit  hold_req = 0;

  task automatic report(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    fault_count++;
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: random back-pressure, with one long hold-off on request.
  initial begin
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 0;
        hold_req = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 23);
      end
    end
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_tvalid && out_tready) begin
      msg = sb.check_word({out_tdata[5:0], out_tdata[11:6], out_tdata[18:12],
                           out_tlast, out_tuser});
      if (msg != "") report(msg);
      words_checked++;
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send(scc_op_t op, int from_v, int to_v);
    while (!steady && $urandom_range(0, 99) < 23) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= op;
    in_tdata <= {4'b0, to_v[5:0], from_v[5:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(op, from_v, to_v);
    if (op == OP_ADD) edges_sent++;
    else runs_sent++;
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_tvalid <= 0;
    @(negedge clk);
    while (sb.expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_count(bit [6:0] value);
    go_idle();
    cfg_wen <= 1;
    cfg_wdata <= value;
    sb.set_vertex_count(value);
    @(negedge clk);
    cfg_wen <= 0;
  endtask

  task automatic run_graph();
    send(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
  endtask

  // One random graph: mostly in-range edges, some with stray endpoints.
  task automatic random_graph(int n, int edges);
    for (int i = 0; i < edges; i++) begin
      if ($urandom_range(0, 9) == 0) send(OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
      else send(OP_ADD, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
      random_items++;
    end
    run_graph();
    random_items++;
  endtask

  initial begin
    int n;
    rst_n = 0;
    cfg_wen = 0;
    cfg_wdata = 0;
    in_tvalid = 0;
    in_tdata = 0;
    in_tuser = OP_ADD;
    repeat (2) @(negedge clk);
    rst_n <= 1;

    // Small cycle with a tail, plus an edge whose endpoint is out of range.
    write_count(7'd4);
    send(OP_ADD, 0, 1);
    send(OP_ADD, 1, 2);
    send(OP_ADD, 2, 0);
    send(OP_ADD, 2, 3);
    send(OP_ADD, 5, 0);
    run_graph();
    // A register value of zero counts as a single vertex.
    write_count(7'd0);
    send(OP_ADD, 0, 0);
    send(OP_ADD, 1, 0);
    run_graph();
    // Values above the maximum clamp to the full vertex range.
    write_count(7'd127);
    send(OP_ADD, 63, 0);
    send(OP_ADD, 0, 63);
    send(OP_ADD, 62, 63);
    run_graph();
    // Lowering the count after loading hides edges on the upper vertices.
    write_count(7'd64);
    send(OP_ADD, 10, 20);
    send(OP_ADD, 20, 10);
    send(OP_ADD, 3, 40);
    send(OP_ADD, 2, 3);
    write_count(7'd8);
    run_graph();
    // Empty graph on one vertex, and a run straight after.
    write_count(7'd1);
    run_graph();
    run_graph();

    // Fill the edge store past capacity on a small graph, with no idling on either side.
    write_count(7'd6);
    steady = 1;
    for (int i = 0; i < NE + 1; i++) send(OP_ADD, $urandom_range(0, 5), $urandom_range(0, 5));
    steady = 0;
    // Hold the receiver through the run while the sender keeps offering a second graph.
    hold_req = 1;
    run_graph();
    random_graph(6, 4);

    while (random_items < 20) begin
      case ($urandom_range(0, 9))
        0: n = 64;
        1: n = $urandom_range(65, 127);
        default: n = $urandom_range(1, 12);
      endcase
      write_count(n[6:0]);
      if (n > NV) n = NV;
      random_graph(n, $urandom_range(0, (3 * n > 24) ? 24 : 3 * n));
    end

    go_idle();
    $display("Ran %0d decompositions over %0d edge words, %0d result words checked.",
             runs_sent, edges_sent, words_checked);
    $display("Covered clamped vertex counts, dropped edges, a full edge store and a long stall.");
    if (fault_count == 0 && sb.expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d faults, %0d words still expected", fault_count, sb.expected_words.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> strongly_connected_components.f
rtl/scc_pkg.sv
rtl/scc_ram.sv
rtl/strongly_connected_components.sv
tb/tb_strongly_connected_components.sv
